// File: hdl/fifo_size_weighted_cache_defines.svh
// Assertion macros for the segment cache.
`ifndef FIFO_SIZE_WEIGHTED_CACHE_DEFINES_SVH
`define FIFO_SIZE_WEIGHTED_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
`define FSW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define FSW_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FSW_ASSERT(lbl, clk, rst_n, prop)
`define FSW_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: hdl/fswc_pkg.sv
// Shared types and constants for the segment cache.
package fswc_pkg;
  localparam int unsigned Entries = 64;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOTFND = 2'd1;
  localparam logic [1:0] ST_TOOBIG = 2'd2;
  localparam logic [1:0] ST_DUP    = 2'd3;

  localparam logic [31:0] CapacityReset = 32'd1048576;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] video_key;
    logic [15:0] segment_index;
    logic [31:0] seg_size;
    logic [15:0] item_handle;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] stored_size;
    logic [15:0] stored_handle;
    logic [6:0]  evicted_count;
    logic [31:0] used_size;
    logic [31:0] read_ops;
    logic [31:0] write_ops;
    logic [1:0]  status;
  } rsp_t;
endpackage

// File: hdl/fswc_req_if.sv
// Request and response handshake channels.
interface fswc_req_if;
  logic               valid;
  logic               ready;
  fswc_pkg::req_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fswc_rsp_if;
  logic               valid;
  logic               ready;
  fswc_pkg::rsp_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/fswc_cfg.sv
// APB register file holding the capacity register.
module fswc_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] capacity_o
);
  import fswc_pkg::*;
  logic [31:0] cap_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      cap_q <= pwdata;
    end
  end
  assign prdata = (paddr == 2'd0) ? cap_q : 32'd0;
  assign capacity_o = cap_q;
endmodule

// File: hdl/fifo_size_weighted_cache.sv
// Top level: segment cache with size-weighted FIFO replacement.
// Usage:
//  req: one transfer per operation (kind, key, segment, size, handle).
//  rsp: one transfer per operation with hit, size, handle, evictions,
//       used size, counters and status. A response register sits on rsp.
//  cfg: APB port, capacity at byte address 0. Write only when idle.
// Sequencing (request transfer to response valid): one shared sequencer walks
//  the slot table one slot per cycle through a registered read port.
//  Lookup, duplicate insert: key search over all slots, then the decision.
//  Delete: key search, then an unlink of the slot when the key is found.
//  Insert: key search, one unlink of the oldest entry per eviction, then a
//  scan from slot 0 for the lowest free slot, then the new entry is linked.
//  Clear, oversize insert: no search. req is ready only while the sequencer
//  is idle and the response register is empty, so the next request is
//  taken no sooner than the cycle after the response transfer.
// Reset: all slots invalid, counters and used size zero, capacity 1 MiB.
//  The slot arrays need no clearing pass (only valid slots are used).
// Stall: a pending response holds until taken; no new request is taken
//  until then.
`include "fifo_size_weighted_cache_defines.svh"
module fifo_size_weighted_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  fswc_req_if.sink    req,
  fswc_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fswc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1; // walk slots comparing key
  localparam logic [2:0] S_DEC   = 3'd2; // act on search result
  localparam logic [2:0] S_EVICT = 3'd3; // unlink oldest while too full
  localparam logic [2:0] S_FREE  = 3'd4; // find lowest free slot
  localparam logic [2:0] S_LINK  = 3'd5; // write new entry
  localparam logic [2:0] S_UNLNK = 3'd6; // unlink target slot
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [31:0] capacity;
  fswc_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .capacity_o(capacity)
  );

  // slot storage: arrays with one registered read port at raddr
  logic [Entries-1:0] valid_q;
  logic [31:0] vid_m [Entries];
  logic [15:0] seg_m [Entries];
  logic [31:0] size_m [Entries];
  logic [15:0] hnd_m [Entries];
  logic [IdxW-1:0] newer_m [Entries];
  logic [IdxW-1:0] older_m [Entries];
  logic [31:0] vid_rd_q;
  logic [15:0] seg_rd_q;
  logic [31:0] size_rd_q;
  logic [15:0] hnd_rd_q;
  logic [IdxW-1:0] newer_rd_q;
  logic [IdxW-1:0] older_rd_q;

  logic [2:0] state_q;
  req_t r_q;
  logic [CntW-1:0] idx_q;       // walk index, one wider to hold Entries
  logic found_q;
  logic [IdxW-1:0] fidx_q;
  logic [31:0] fsize_q;         // size of the matching slot
  logic [15:0] fhnd_q;          // handle of the matching slot
  logic [IdxW-1:0] newest_q, oldest_q;
  logic [CntW-1:0] count_q;
  logic [31:0] used_q, rd_q, wr_q;
  logic [6:0] evict_q;
  logic [IdxW-1:0] tgt_q;       // slot being unlinked
  logic del_q;                  // unlink is a delete (not eviction)
  rsp_t out_q;
  logic out_v_q;

  logic [IdxW-1:0] idx;
  assign idx = idx_q[IdxW-1:0];
  // read data arrives in the cycle after its address: compare the previous slot
  logic [IdxW-1:0] pidx;
  assign pidx = IdxW'(idx_q - CntW'(1));
  logic key_eq;
  assign key_eq = (idx_q != '0) && valid_q[pidx] && vid_rd_q == r_q.video_key
                  && seg_rd_q == r_q.segment_index;
  logic [32:0] need;
  assign need = {1'b0, used_q} + {1'b0, r_q.seg_size};
  logic must_evict;
  assign must_evict = (count_q != '0) &&
                      (need > {1'b0, capacity} || count_q == CntW'(Entries));

  // read address: the slot whose fields the next state needs
  logic [IdxW-1:0] raddr;
  always_comb begin
    unique case (state_q)
      S_SRCH:  raddr = idx;
      S_DEC:   raddr = fidx_q;
      S_EVICT: raddr = oldest_q;
      default: raddr = tgt_q;
    endcase
  end

  assign req.ready = (state_q == S_IDLE) && !out_v_q;
  assign rsp.valid = out_v_q;
  assign rsp.data = out_q;

  // table reads and writes (unlink and link)
  always_ff @(posedge clk_i) begin
    vid_rd_q <= vid_m[raddr];
    seg_rd_q <= seg_m[raddr];
    size_rd_q <= size_m[raddr];
    hnd_rd_q <= hnd_m[raddr];
    newer_rd_q <= newer_m[raddr];
    older_rd_q <= older_m[raddr];
    if (state_q == S_UNLNK && count_q > CntW'(1)) begin
      if (tgt_q != newest_q) older_m[newer_rd_q] <= older_rd_q;
      if (tgt_q != oldest_q) newer_m[older_rd_q] <= newer_rd_q;
    end
    if (state_q == S_LINK) begin
      vid_m[fidx_q] <= r_q.video_key;
      seg_m[fidx_q] <= r_q.segment_index;
      size_m[fidx_q] <= r_q.seg_size;
      hnd_m[fidx_q] <= r_q.item_handle;
      if (count_q != '0) begin
        newer_m[newest_q] <= fidx_q;
        older_m[fidx_q] <= newest_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      newest_q <= '0;
      oldest_q <= '0;
      count_q <= '0;
      used_q <= '0;
      rd_q <= '0;
      wr_q <= '0;
      out_v_q <= 1'b0;
      idx_q <= '0;
      found_q <= 1'b0;
      fidx_q <= '0;
      fsize_q <= '0;
      fhnd_q <= '0;
      evict_q <= '0;
      tgt_q <= '0;
      del_q <= 1'b0;
      r_q <= '0;
      out_q <= '0;
    end else begin
      if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            r_q <= req.data;
            idx_q <= '0;
            found_q <= 1'b0;
            evict_q <= '0;
            if (req.data.kind == KIND_CLEAR) begin
              out_q <= '0;
              rd_q <= '0;
              wr_q <= '0;
              state_q <= S_DONE;
            end else if (req.data.kind == KIND_INSERT && req.data.seg_size > capacity) begin
              out_q <= '{status: ST_TOOBIG, default: '0};
              state_q <= S_DONE;
            end else begin
              out_q <= '0;
              if (req.data.kind == KIND_LOOKUP) rd_q <= rd_q + 32'd1;
              state_q <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (key_eq && !found_q) begin
            found_q <= 1'b1;
            fidx_q <= pidx;
            fsize_q <= size_rd_q;
            fhnd_q <= hnd_rd_q;
          end
          if (idx_q == CntW'(Entries)) state_q <= S_DEC;
          idx_q <= idx_q + CntW'(1);
        end
        S_DEC: begin
          priority case (r_q.kind)
            KIND_INSERT: begin
              if (found_q) begin
                out_q.status <= ST_DUP;
                state_q <= S_DONE;
              end else begin
                state_q <= S_EVICT;
              end
            end
            default: begin
              if (found_q) begin
                out_q.hit <= 1'b1;
                out_q.stored_size <= fsize_q;
                out_q.stored_handle <= fhnd_q;
                if (r_q.kind == KIND_DELETE) begin
                  tgt_q <= fidx_q;
                  del_q <= 1'b1;
                  state_q <= S_UNLNK;
                end else begin
                  state_q <= S_DONE;
                end
              end else begin
                out_q.status <= ST_NOTFND;
                state_q <= S_DONE;
              end
            end
          endcase
        end
        S_EVICT: begin
          if (must_evict) begin
            tgt_q <= oldest_q;
            del_q <= 1'b0;
            evict_q <= evict_q + 7'd1;
            state_q <= S_UNLNK;
          end else begin
            idx_q <= '0;
            state_q <= S_FREE;
          end
        end
        S_UNLNK: begin
          if (count_q > CntW'(1)) begin
            if (tgt_q == newest_q) newest_q <= older_rd_q;
            if (tgt_q == oldest_q) oldest_q <= newer_rd_q;
          end
          valid_q[tgt_q] <= 1'b0;
          used_q <= used_q - size_rd_q;
          count_q <= count_q - CntW'(1);
          wr_q <= wr_q + 32'd1;
          state_q <= del_q ? S_DONE : S_EVICT;
        end
        S_FREE: begin
          if (!valid_q[idx]) begin
            fidx_q <= idx;
            state_q <= S_LINK;
          end else if (idx_q == CntW'(Entries - 1)) begin
            state_q <= S_DONE;
          end
          idx_q <= idx_q + CntW'(1);
        end
        S_LINK: begin
          valid_q[fidx_q] <= 1'b1;
          if (count_q == '0) oldest_q <= fidx_q;
          newest_q <= fidx_q;
          count_q <= count_q + CntW'(1);
          used_q <= used_q + r_q.seg_size;
          wr_q <= wr_q + 32'd1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          out_q.evicted_count <= evict_q;
          out_q.used_size <= used_q;
          out_q.read_ops <= rd_q;
          out_q.write_ops <= wr_q;
          out_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `FSW_ASSERT(a_cnt_range, clk_i, rst_ni, count_q <= CntW'(Entries))
  `FSW_ASSERT(a_cnt_pop, clk_i, rst_ni, count_q == CntW'($countones(valid_q)))
  `FSW_ASSERT(a_rsp_hold, clk_i, rst_ni, out_v_q && !rsp.ready |=> out_v_q && $stable(out_q))
  `FSW_ASSERT(a_done_next, clk_i, rst_ni, state_q == S_DONE |=> out_v_q)
endmodule
